// ===== rtl/min_plus_shortest_walk_macros.svh =====
// Assertion macros shared by the checker of the lowest cost walk block.
`ifndef MIN_PLUS_SHORTEST_WALK_MACROS_SVH
`define MIN_PLUS_SHORTEST_WALK_MACROS_SVH

// Condition in the same cycle.
`define MPSW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition in the following cycle.
`define MPSW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mpsw_pkg.sv =====
`default_nettype none
package mpsw_pkg;

    localparam int MAXV_DEF      = 16;
    localparam int COST_BITS_DEF = 16;
    localparam int OUT_BITS      = 20;

    localparam logic [4:0] VC_RESET = 5'd16;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic [1:0] ST_VERTEX    = 2'd0;
    localparam logic [1:0] ST_NO_WALK   = 2'd1;
    localparam logic [1:0] ST_NEG_CYCLE = 2'd2;
    localparam logic [1:0] ST_TRUNC     = 2'd3;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_INIT, S_INITW, S_RUN, S_DRAIN, S_DIAG, S_DIAGW,
        S_CHK, S_HOPW, S_STEP, S_STEPW, S_FIN
    } t_state;

    typedef enum logic [1:0] {
        OP_NONE, OP_INIT, OP_PROD, OP_DIAG
    } t_op;

    // Control of the add-compare unit for one product term.
    typedef struct packed {
        logic vld;
        logic first;
        logic keqj;
    } t_acc_ctl;

endpackage
`default_nettype wire

// ===== rtl/mpsw_ram.sv =====
`default_nettype none
module mpsw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/mpsw_acc.sv =====
`default_nettype none
// One add-compare step of a min-plus product, with the running minimum and
// next hop of the cell being built.
module mpsw_acc #(
    parameter int CW = 21,
    parameter int IB = 16,
    parameter int VB = 4
) (
    input  wire logic                   i_clk,
    input  wire mpsw_pkg::t_acc_ctl     i_ctl,
    input  wire logic                   i_a_fin,
    input  wire logic signed [CW-1:0]   i_a_cost,
    input  wire logic                   i_b_fin,
    input  wire logic signed [IB-1:0]   i_b_cost,
    input  wire logic                   i_h_set,
    input  wire logic [VB-1:0]          i_h_hop,
    output logic                        o_fin,
    output logic signed [CW-1:0]        o_cost,
    output logic                        o_set,
    output logic [VB-1:0]               o_hop,
    output logic                        o_chg
);

    logic                 r_fin;
    logic signed [CW-1:0] r_cost;
    logic                 r_set;
    logic [VB-1:0]        r_hop;
    logic                 r_chg;

    logic                 fin_in;
    logic                 chg_in;
    logic                 hv_set;
    logic [VB-1:0]        hv_hop;
    logic signed [CW-1:0] sum;
    logic                 take;

    always_comb begin
        fin_in = i_ctl.first ? 1'b0 : r_fin;
        chg_in = i_ctl.first ? 1'b0 : r_chg;
        // The cell's own hop, when read as a term, is the value built so far.
        if (i_ctl.keqj && chg_in) begin
            hv_set = r_set;
            hv_hop = r_hop;
        end else begin
            hv_set = i_h_set;
            hv_hop = i_h_hop;
        end
        sum  = i_a_cost + CW'(i_b_cost);
        take = i_a_fin && i_b_fin && (!fin_in || (r_cost > sum));
        o_fin  = take || fin_in;
        o_cost = take ? sum : r_cost;
        o_set  = take ? hv_set : r_set;
        o_hop  = take ? hv_hop : r_hop;
        o_chg  = take || chg_in;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.vld) begin
            r_fin  <= o_fin;
            r_cost <= o_cost;
            r_set  <= o_set;
            r_hop  <= o_hop;
            r_chg  <= o_chg;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/min_plus_shortest_walk.sv =====
`default_nettype none
// Lowest cost walk between two vertices of a directed weighted graph, found by
// repeated min-plus products of a cost matrix. Requests on the input channel
// carry a command: clear loads the vertex count from the configuration
// register and resets the graph, add edge writes one cell of the edge matrix
// (edges naming vertices outside the graph are dropped), and query runs the
// products and returns the walk as a series of results, the last one flagged.
// The edge matrix, the two work matrices and the next-hop table live in three
// simple dual-port synchronous memories (one write port and one registered
// read port each), and all arithmetic runs through one add-compare unit fed
// by one read of each memory per cycle. After reset the block sweeps the edge
// memory once before it takes its first request; a clear takes the same sweep.
// A query with n vertices in use copies the edge matrix, runs n - 2 min-plus
// products (none for fewer than three), checks the diagonal for a negative
// cycle, and then returns the walk one vertex per result, waiting on the
// output channel when it stalls. One request is worked on at a time; the
// finished last result may wait in the output register while the next
// request is taken.
module min_plus_shortest_walk #(
    parameter int MAX_VERTICES = mpsw_pkg::MAXV_DEF,
    parameter int COST_BITS    = mpsw_pkg::COST_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [4:0]                         i_cfg_data,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [1:0]                         i_cmd,
    input  wire logic [3:0]                         i_from_vertex,
    input  wire logic [3:0]                         i_to_vertex,
    input  wire logic signed [15:0]                 i_edge_cost,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [1:0]                              o_status,
    output logic [3:0]                              o_vertex,
    output logic signed [mpsw_pkg::OUT_BITS-1:0]    o_walk_cost,
    output logic                                    o_last
);

    localparam int VB   = $clog2(MAX_VERTICES);
    localparam int NW   = $clog2(MAX_VERTICES + 1);
    localparam int CA   = 2 * VB;
    localparam int IB   = (COST_BITS < 16) ? COST_BITS : 16;
    localparam int CW   = IB + VB + 1;
    localparam int OB   = mpsw_pkg::OUT_BITS;
    localparam int SW   = (CW > OB) ? CW : OB;
    localparam int CMPW = (NW > 4) ? NW : 4;
    localparam int VCW  = (NW > 5) ? NW : 5;
    localparam int N_RST = (16 > MAX_VERTICES) ? MAX_VERTICES : 16;
    localparam logic [VB-1:0] VMAX = VB'(MAX_VERTICES - 1);
    localparam logic signed [SW-1:0] OMAX = {{(SW-OB+1){1'b0}}, {(OB-1){1'b1}}};
    localparam logic signed [SW-1:0] OMIN = {{(SW-OB+1){1'b1}}, {(OB-1){1'b0}}};

    typedef struct packed {
        mpsw_pkg::t_op op;
        logic          first;
        logic          lastk;
        logic          keqj;
        logic [VB-1:0] i;
        logic [VB-1:0] j;
    } t_s1;

    // Control registers.
    mpsw_pkg::t_state r_state, n_state;
    logic [4:0]       r_vcount;
    logic [NW-1:0]    r_n, n_n;
    logic [VB-1:0]    r_i, n_i;
    logic [VB-1:0]    r_j, n_j;
    logic [VB-1:0]    r_k, n_k;
    logic [NW-1:0]    r_step, n_step;
    logic             r_bank, n_bank;
    logic             r_neg, n_neg;
    t_s1              r_s1, n_s1;
    logic             r_fwd_hit, n_fwd_hit;
    logic             r_ov, n_ov;

    // Payload registers.
    logic [VB-1:0]        r_src, n_src;
    logic [VB-1:0]        r_dst, n_dst;
    logic [VB-1:0]        r_cur, n_cur;
    logic [VB-1:0]        r_wcnt, n_wcnt;
    logic signed [CW-1:0] r_cost, n_cost;
    logic [1:0]           r_fin_st, n_fin_st;
    logic [VB:0]          r_fwd_data;
    logic [1:0]           r_ostat;
    logic [3:0]           r_overt;
    logic signed [OB-1:0] r_ocost;
    logic                 r_olast;

    // Memory ports.
    logic             e_we, e_re;
    logic [CA-1:0]    e_waddr, e_raddr;
    logic [IB+1:0]    e_wdata, e_rdata;
    logic             w_we, w_re;
    logic [CA:0]      w_waddr, w_raddr;
    logic [CW:0]      w_wdata, w_rdata;
    logic             h_we, h_re;
    logic [CA-1:0]    h_waddr, h_raddr;
    logic [VB:0]      h_wdata, h_rdata, hop_rd;

    // Add-compare unit.
    mpsw_pkg::t_acc_ctl   acc_ctl;
    logic                 acc_fin, acc_set, acc_chg;
    logic signed [CW-1:0] acc_cost;
    logic [VB-1:0]        acc_hop;

    logic          in_acc;
    logic          out_free;
    logic [VB-1:0] nm1;
    logic          sweep_last;
    logic          prod_last;
    logic          src_out, dst_out;
    logic          in_range_edge;
    logic [NW-1:0] n_sat;
    logic          hop_ok;
    logic          walk_stop;
    logic          emit;
    logic [1:0]    e_status;
    logic          e_zero;
    logic          e_last;
    logic signed [SW-1:0] cost_ext;
    logic signed [OB-1:0] cost_sat;

    mpsw_ram #(.WIDTH(IB + 2), .DEPTH(2 ** CA)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_waddr),
        .i_wdata (e_wdata),
        .i_re    (e_re),
        .i_raddr (e_raddr),
        .o_rdata (e_rdata)
    );

    // Two banks of the running cost matrix; products ping-pong between them.
    mpsw_ram #(.WIDTH(CW + 1), .DEPTH(2 ** (CA + 1))) u_walk_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    mpsw_ram #(.WIDTH(VB + 1), .DEPTH(2 ** CA)) u_hop_ram (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (h_wdata),
        .i_re    (h_re),
        .i_raddr (h_raddr),
        .o_rdata (h_rdata)
    );

    assign acc_ctl.vld   = (r_s1.op == mpsw_pkg::OP_PROD);
    assign acc_ctl.first = r_s1.first;
    assign acc_ctl.keqj  = r_s1.keqj;

    mpsw_acc #(.CW(CW), .IB(IB), .VB(VB)) u_acc (
        .i_clk    (i_clk),
        .i_ctl    (acc_ctl),
        .i_a_fin  (w_rdata[CW]),
        .i_a_cost (w_rdata[CW-1:0]),
        .i_b_fin  (e_rdata[IB]),
        .i_b_cost (e_rdata[IB-1:0]),
        .i_h_set  (hop_rd[VB]),
        .i_h_hop  (hop_rd[VB-1:0]),
        .o_fin    (acc_fin),
        .o_cost   (acc_cost),
        .o_set    (acc_set),
        .o_hop    (acc_hop),
        .o_chg    (acc_chg)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == mpsw_pkg::S_IDLE);
    assign o_out_valid = r_ov;
    assign o_status    = r_ostat;
    assign o_vertex    = r_overt;
    assign o_walk_cost = r_ocost;
    assign o_last      = r_olast;

    // Shared decode used by both control blocks.
    always_comb begin
        in_acc     = i_in_valid && o_in_ready;
        out_free   = !r_ov || i_out_ready;
        nm1        = VB'(r_n - NW'(1));
        sweep_last = (r_i == VMAX) && (r_j == VMAX);
        prod_last  = (r_i == nm1) && (r_j == nm1) && (r_k == nm1);
        src_out    = CMPW'(i_from_vertex) >= CMPW'(r_n);
        dst_out    = CMPW'(i_to_vertex) >= CMPW'(r_n);
        in_range_edge = !src_out && !dst_out;
        if (r_vcount == 5'd0) begin
            n_sat = NW'(1);
        end else if (VCW'(r_vcount) > VCW'(MAX_VERTICES)) begin
            n_sat = NW'(MAX_VERTICES);
        end else begin
            n_sat = NW'(r_vcount);
        end
        // A write to the hop entry being read in the same cycle is forwarded, so the read returns the new value.
        hop_rd    = r_fwd_hit ? r_fwd_data : h_rdata;
        hop_ok    = hop_rd[VB] && (CMPW'(hop_rd[VB-1:0]) < CMPW'(r_n));
        walk_stop = (r_wcnt == VMAX) || !hop_ok;
        cost_ext  = SW'(r_cost);
        if (cost_ext > OMAX) begin
            cost_sat = OB'(OMAX);
        end else if (cost_ext < OMIN) begin
            cost_sat = OB'(OMIN);
        end else begin
            cost_sat = OB'(cost_ext);
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mpsw_pkg::S_CLEAR: begin
                if (sweep_last) n_state = mpsw_pkg::S_IDLE;
            end
            mpsw_pkg::S_IDLE: begin
                if (in_acc) begin
                    priority if (i_cmd == mpsw_pkg::CMD_CLEAR) begin
                        n_state = mpsw_pkg::S_CLEAR;
                    end else if (i_cmd == mpsw_pkg::CMD_QUERY) begin
                        n_state = (src_out || dst_out) ? mpsw_pkg::S_FIN
                                                       : mpsw_pkg::S_INIT;
                    end else begin
                        n_state = mpsw_pkg::S_IDLE;
                    end
                end
            end
            mpsw_pkg::S_INIT: begin
                if (sweep_last) n_state = mpsw_pkg::S_INITW;
            end
            mpsw_pkg::S_INITW: begin
                n_state = (r_step == '0) ? mpsw_pkg::S_DIAG : mpsw_pkg::S_RUN;
            end
            mpsw_pkg::S_RUN: begin
                if (prod_last) n_state = mpsw_pkg::S_DRAIN;
            end
            mpsw_pkg::S_DRAIN: begin
                n_state = (r_step == NW'(1)) ? mpsw_pkg::S_DIAG : mpsw_pkg::S_RUN;
            end
            mpsw_pkg::S_DIAG: begin
                if (r_i == nm1) n_state = mpsw_pkg::S_DIAGW;
            end
            mpsw_pkg::S_DIAGW: begin
                n_state = mpsw_pkg::S_CHK;
            end
            mpsw_pkg::S_CHK: begin
                n_state = r_neg ? mpsw_pkg::S_FIN : mpsw_pkg::S_HOPW;
            end
            mpsw_pkg::S_HOPW: begin
                n_state = hop_rd[VB] ? mpsw_pkg::S_STEP : mpsw_pkg::S_FIN;
            end
            mpsw_pkg::S_STEP: begin
                if (r_cur != r_dst) begin
                    n_state = mpsw_pkg::S_STEPW;
                end else if (out_free) begin
                    n_state = mpsw_pkg::S_IDLE;
                end
            end
            mpsw_pkg::S_STEPW: begin
                if (out_free) n_state = walk_stop ? mpsw_pkg::S_IDLE : mpsw_pkg::S_STEP;
            end
            mpsw_pkg::S_FIN: begin
                if (out_free) n_state = mpsw_pkg::S_IDLE;
            end
            default: n_state = mpsw_pkg::S_IDLE;
        endcase
    end

    // Datapath control, memory ports and results.
    always_comb begin
        n_n       = r_n;
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        n_step    = r_step;
        n_bank    = r_bank;
        n_neg     = r_neg;
        n_src     = r_src;
        n_dst     = r_dst;
        n_cur     = r_cur;
        n_wcnt    = r_wcnt;
        n_cost    = r_cost;
        n_fin_st  = r_fin_st;
        n_s1      = '0;
        n_s1.op   = mpsw_pkg::OP_NONE;
        e_we      = 1'b0;
        e_waddr   = {r_i, r_j};
        e_wdata   = {1'b0, (r_i == r_j), IB'(0)};
        e_re      = 1'b0;
        e_raddr   = {r_i, r_j};
        w_re      = 1'b0;
        w_raddr   = {r_bank, r_i, r_k};
        h_re      = 1'b0;
        h_raddr   = {r_i, r_k};
        emit      = 1'b0;
        e_status  = mpsw_pkg::ST_VERTEX;
        e_zero    = 1'b0;
        e_last    = 1'b1;

        // Sweep counter over every cell.
        if ((r_state == mpsw_pkg::S_CLEAR) || (r_state == mpsw_pkg::S_INIT)) begin
            n_j = r_j + VB'(1);
            if (r_j == VMAX) begin
                n_j = '0;
                n_i = (r_i == VMAX) ? '0 : r_i + VB'(1);
            end
        end

        unique case (r_state)
            mpsw_pkg::S_CLEAR: begin
                e_we = 1'b1;
            end
            mpsw_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_i = '0;
                    n_j = '0;
                    n_k = '0;
                    n_src  = VB'(i_from_vertex);
                    n_dst  = VB'(i_to_vertex);
                    n_bank = 1'b0;
                    n_neg  = 1'b0;
                    n_fin_st = mpsw_pkg::ST_NO_WALK;
                    n_step = (r_n > NW'(2)) ? r_n - NW'(2) : '0;
                    if (i_cmd == mpsw_pkg::CMD_CLEAR) begin
                        n_n = n_sat;
                    end
                    if ((i_cmd == mpsw_pkg::CMD_ADD) && in_range_edge) begin
                        e_we    = 1'b1;
                        e_waddr = {VB'(i_from_vertex), VB'(i_to_vertex)};
                        e_wdata = {1'b1, 1'b1, i_edge_cost[IB-1:0]};
                    end
                end
            end
            mpsw_pkg::S_INIT: begin
                e_re    = 1'b1;
                n_s1.op = mpsw_pkg::OP_INIT;
                n_s1.i  = r_i;
                n_s1.j  = r_j;
            end
            mpsw_pkg::S_INITW: begin
                n_i = '0;
                n_j = '0;
                n_k = '0;
            end
            mpsw_pkg::S_RUN: begin
                // Term k of cell (i, j): walk[i][k] + edge[k][j], hop[i][k].
                e_re       = 1'b1;
                e_raddr    = {r_k, r_j};
                w_re       = 1'b1;
                h_re       = 1'b1;
                n_s1.op    = mpsw_pkg::OP_PROD;
                n_s1.first = (r_k == '0);
                n_s1.lastk = (r_k == nm1);
                n_s1.keqj  = (r_k == r_j);
                n_s1.i     = r_i;
                n_s1.j     = r_j;
                n_k = r_k + VB'(1);
                if (r_k == nm1) begin
                    n_k = '0;
                    n_j = r_j + VB'(1);
                    if (r_j == nm1) begin
                        n_j = '0;
                        n_i = (r_i == nm1) ? '0 : r_i + VB'(1);
                    end
                end
            end
            mpsw_pkg::S_DRAIN: begin
                n_bank = !r_bank;
                n_step = r_step - NW'(1);
                n_i = '0;
            end
            mpsw_pkg::S_DIAG: begin
                w_re    = 1'b1;
                w_raddr = {r_bank, r_i, r_i};
                n_s1.op = mpsw_pkg::OP_DIAG;
                n_i = r_i + VB'(1);
            end
            mpsw_pkg::S_DIAGW: begin
                n_i = '0;
            end
            mpsw_pkg::S_CHK: begin
                w_re     = 1'b1;
                w_raddr  = {r_bank, r_src, r_dst};
                h_re     = 1'b1;
                h_raddr  = {r_src, r_dst};
                n_fin_st = mpsw_pkg::ST_NEG_CYCLE;
            end
            mpsw_pkg::S_HOPW: begin
                n_fin_st = mpsw_pkg::ST_NO_WALK;
                n_cost   = w_rdata[CW] ? $signed(w_rdata[CW-1:0]) : '0;
                n_cur    = r_src;
                n_wcnt   = '0;
            end
            mpsw_pkg::S_STEP: begin
                if (r_cur == r_dst) begin
                    emit = 1'b1;
                end else begin
                    h_re    = 1'b1;
                    h_raddr = {r_cur, r_dst};
                end
            end
            mpsw_pkg::S_STEPW: begin
                emit     = 1'b1;
                e_status = walk_stop ? mpsw_pkg::ST_TRUNC : mpsw_pkg::ST_VERTEX;
                e_last   = walk_stop;
                if (out_free) begin
                    n_cur  = hop_rd[VB-1:0];
                    n_wcnt = r_wcnt + VB'(1);
                end
            end
            mpsw_pkg::S_FIN: begin
                emit     = 1'b1;
                e_status = r_fin_st;
                e_zero   = 1'b1;
            end
            default: begin
                n_s1.op = mpsw_pkg::OP_NONE;
            end
        endcase

        // Stage after the memory reads: copy, accumulate or check.
        w_we    = 1'b0;
        w_waddr = {1'b0, r_s1.i, r_s1.j};
        w_wdata = {e_rdata[IB], CW'($signed(e_rdata[IB-1:0]))};
        h_we    = 1'b0;
        h_waddr = {r_s1.i, r_s1.j};
        h_wdata = {e_rdata[IB+1], r_s1.j};
        unique case (r_s1.op)
            mpsw_pkg::OP_INIT: begin
                w_we = 1'b1;
                h_we = 1'b1;
            end
            mpsw_pkg::OP_PROD: begin
                if (r_s1.lastk) begin
                    w_we    = 1'b1;
                    w_waddr = {!r_bank, r_s1.i, r_s1.j};
                    w_wdata = {acc_fin, acc_cost};
                    h_we    = acc_chg;
                    h_wdata = {acc_set, acc_hop};
                end
            end
            mpsw_pkg::OP_DIAG: begin
                if (w_rdata[CW] && w_rdata[CW-1]) n_neg = 1'b1;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase

        n_fwd_hit = h_re && h_we && (h_raddr == h_waddr);
        n_ov = (emit && out_free) ? 1'b1 : (r_ov && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mpsw_pkg::S_CLEAR;
            r_vcount  <= mpsw_pkg::VC_RESET;
            r_n       <= NW'(N_RST);
            r_i       <= '0;
            r_j       <= '0;
            r_k       <= '0;
            r_step    <= '0;
            r_bank    <= 1'b0;
            r_neg     <= 1'b0;
            r_s1      <= '0;
            r_fwd_hit <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_vcount <= i_cfg_data;
            end
            r_n       <= n_n;
            r_i       <= n_i;
            r_j       <= n_j;
            r_k       <= n_k;
            r_step    <= n_step;
            r_bank    <= n_bank;
            r_neg     <= n_neg;
            r_s1      <= n_s1;
            r_fwd_hit <= n_fwd_hit;
            r_ov      <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src      <= n_src;
        r_dst      <= n_dst;
        r_cur      <= n_cur;
        r_wcnt     <= n_wcnt;
        r_cost     <= n_cost;
        r_fin_st   <= n_fin_st;
        r_fwd_data <= h_wdata;
        if (emit && out_free) begin
            r_ostat <= e_status;
            r_overt <= e_zero ? 4'd0 : 4'(r_cur);
            r_ocost <= e_zero ? '0 : cost_sat;
            r_olast <= e_last;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/mpsw_checker.sv =====
`default_nettype none
`include "min_plus_shortest_walk_macros.svh"
module mpsw_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                i_cfg_valid,
    input wire logic                                o_cfg_ready,
    input wire logic [4:0]                          i_cfg_data,
    input wire logic                                i_in_valid,
    input wire logic                                o_in_ready,
    input wire logic [1:0]                          i_cmd,
    input wire logic [3:0]                          i_from_vertex,
    input wire logic [3:0]                          i_to_vertex,
    input wire logic signed [15:0]                  i_edge_cost,
    input wire logic                                o_out_valid,
    input wire logic                                i_out_ready,
    input wire logic [1:0]                          o_status,
    input wire logic [3:0]                          o_vertex,
    input wire logic signed [mpsw_pkg::OUT_BITS-1:0] o_walk_cost,
    input wire logic                                o_last
);

    // A stalled result holds.
    `MPSW_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_status) && $stable(o_vertex) && $stable(o_walk_cost) && $stable(o_last), "result changed while stalled")

    // Any status other than a walk vertex closes the query.
    `MPSW_ASSERT_NOW(a_status_last, o_out_valid && (o_status != mpsw_pkg::ST_VERTEX), o_last, "terminal status without last")

    // No walk and negative cycle results carry no vertex and no cost.
    `MPSW_ASSERT_NOW(a_empty_zero, o_out_valid && ((o_status == mpsw_pkg::ST_NO_WALK) || (o_status == mpsw_pkg::ST_NEG_CYCLE)), (o_vertex == 4'd0) && (o_walk_cost == '0), "empty result not zero")

    // A query keeps the block busy for at least the next cycle.
    `MPSW_ASSERT_NEXT(a_query_busy, i_in_valid && o_in_ready && (i_cmd == mpsw_pkg::CMD_QUERY), !o_in_ready, "request taken during query")

endmodule

bind min_plus_shortest_walk mpsw_checker u_mpsw_checker (.*);
`default_nettype wire

// ===== tb/tb_min_plus_shortest_walk.sv =====
`timescale 1ns / 1ps

module tb_min_plus_shortest_walk;

    localparam int NV = 16;
    localparam int NCELL = NV * NV;
    localparam longint COST_LO = -524288;
    localparam longint COST_HI = 524287;
    // Command code that the block does not use.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // One result of a query as it should appear on the output ports.
    typedef struct {
        logic [1:0]        status;
        logic [3:0]        vertex;
        logic signed [19:0] cost;
        logic              last;
    } t_walk_res;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [4:0]         i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [1:0]         i_cmd;
    logic [3:0]         i_from_vertex;
    logic [3:0]         i_to_vertex;
    logic signed [15:0] i_edge_cost;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [1:0]         o_status;
    logic [3:0]         o_vertex;
    logic signed [19:0] o_walk_cost;
    logic               o_last;

    min_plus_shortest_walk u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_from_vertex (i_from_vertex),
        .i_to_vertex   (i_to_vertex),
        .i_edge_cost   (i_edge_cost),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_vertex      (o_vertex),
        .o_walk_cost   (o_walk_cost),
        .o_last        (o_last)
    );

    // The shadow graph. Costs are kept wide so that sums never wrap; a cell
    // that is not finite stands for infinity.
    longint    graph_cost[NCELL];
    bit        graph_fin[NCELL];
    bit        graph_edge[NCELL];
    logic [4:0] count_reg;
    int        active_count;

    t_walk_res expected_walk[$];
    int        error_count;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        hold_left;

    // The clock runs free with a 12 ns period.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // A clear loads the vertex count from the register, saturated to the
    // legal range, and leaves only the zero diagonal finite.
    function automatic void graph_clear();
        if (count_reg < 1) active_count = 1;
        else if (count_reg > NV) active_count = NV;
        else active_count = count_reg;
        for (int i = 0; i < NCELL; i++) begin
            graph_cost[i] = 0;
            graph_fin[i]  = (i / NV) == (i % NV);
            graph_edge[i] = 1'b0;
        end
    endfunction

    function automatic void push_walk(input logic [1:0] st, input int v, input longint c,
                                      input bit lst);
        t_walk_res r;
        if (c < COST_LO) c = COST_LO;
        if (c > COST_HI) c = COST_HI;
        r.status = st;
        r.vertex = v[3:0];
        r.cost   = c[19:0];
        r.last   = lst;
        expected_walk.push_back(r);
    endfunction

    // Runs the min-plus products with next-hop tracking and queues every
    // result that the query should return.
    function automatic void predict_walk(input int src, input int dst);
        longint run_cost[NCELL];
        bit     run_fin[NCELL];
        longint nxt_cost[NCELL];
        bit     nxt_fin[NCELL];
        int     hop[NCELL];
        bit     hop_ok[NCELL];
        int     n, cnt, cur, h, ij, ik, kj;
        longint s, total;
        n = active_count;
        if (src >= n || dst >= n) begin
            push_walk(mpsw_pkg::ST_NO_WALK, 0, 0, 1'b1);
            return;
        end
        for (int i = 0; i < NCELL; i++) begin
            hop_ok[i]   = graph_edge[i];
            hop[i]      = i % NV;
            run_cost[i] = graph_cost[i];
            run_fin[i]  = graph_fin[i];
            nxt_cost[i] = graph_cost[i];
            nxt_fin[i]  = graph_fin[i];
        end
        for (int step = 2; step < n; step++) begin
            for (int i = 0; i < n; i++) begin
                for (int j = 0; j < n; j++) begin
                    ij = i * NV + j;
                    nxt_fin[ij]  = 1'b0;
                    nxt_cost[ij] = 0;
                    for (int k = 0; k < n; k++) begin
                        ik = i * NV + k;
                        kj = k * NV + j;
                        if (run_fin[ik] && graph_fin[kj]) begin
                            s = run_cost[ik] + graph_cost[kj];
                            // Only a strictly lower sum moves the next hop.
                            if (!nxt_fin[ij] || nxt_cost[ij] > s) begin
                                nxt_fin[ij]  = 1'b1;
                                nxt_cost[ij] = s;
                                hop[ij]      = hop[ik];
                                hop_ok[ij]   = hop_ok[ik];
                            end
                        end
                    end
                end
            end
            run_cost = nxt_cost;
            run_fin  = nxt_fin;
        end
        for (int i = 0; i < n; i++) begin
            if (nxt_fin[i * NV + i] && nxt_cost[i * NV + i] < 0) begin
                push_walk(mpsw_pkg::ST_NEG_CYCLE, 0, 0, 1'b1);
                return;
            end
        end
        if (!hop_ok[src * NV + dst]) begin
            push_walk(mpsw_pkg::ST_NO_WALK, 0, 0, 1'b1);
            return;
        end
        total = nxt_fin[src * NV + dst] ? nxt_cost[src * NV + dst] : 0;
        cur = src;
        cnt = 0;
        forever begin
            if (cur == dst) begin
                push_walk(mpsw_pkg::ST_VERTEX, cur, total, 1'b1);
                return;
            end
            h = hop[cur * NV + dst];
            if (cnt == NV - 1 || !(hop_ok[cur * NV + dst] && h < n)) begin
                push_walk(mpsw_pkg::ST_TRUNC, cur, total, 1'b1);
                return;
            end
            push_walk(mpsw_pkg::ST_VERTEX, cur, total, 1'b0);
            cnt++;
            cur = h;
        end
    endfunction

    function automatic void apply_request(input logic [1:0] cmd, input int a, input int b,
                                          input logic signed [15:0] c);
        if (cmd == mpsw_pkg::CMD_CLEAR) begin
            graph_clear();
        end else if (cmd == mpsw_pkg::CMD_ADD) begin
            if (a < active_count && b < active_count) begin
                graph_cost[a * NV + b] = longint'(c);
                graph_fin[a * NV + b]  = 1'b1;
                graph_edge[a * NV + b] = 1'b1;
            end
        end else if (cmd == mpsw_pkg::CMD_QUERY) begin
            predict_walk(a, b);
        end
    endfunction

    // Offers one request. The valid stays high from the last accepted request
    // when no gap is drawn, so it is never lowered and raised in one step.
    task automatic send_request(input logic [1:0] cmd, input int a, input int b,
                                input logic signed [15:0] c);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_cmd         = cmd;
        i_from_vertex = a[3:0];
        i_to_vertex   = b[3:0];
        i_edge_cost   = c;
        do @(posedge i_clk); while (!o_in_ready);
        apply_request(cmd, a, b, c);
    endtask

    // Drops valid, then waits until every queued result has come out and the clear
    // sweep or any other background work has had time to end.
    task automatic wait_quiet();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_walk.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [4:0] value);
        wait_quiet();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        count_reg = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Receiver: random idling, or a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Every accepted result is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_walk_res e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_walk.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                e = expected_walk.pop_front();
                if (o_status !== e.status)
                    report_mismatch($sformatf("status %0d, want %0d", o_status, e.status));
                if (o_vertex !== e.vertex)
                    report_mismatch($sformatf("vertex %0d, want %0d", o_vertex, e.vertex));
                if (o_walk_cost !== e.cost)
                    report_mismatch($sformatf("cost %0d, want %0d", o_walk_cost, e.cost));
                if (o_last !== e.last)
                    report_mismatch($sformatf("last %0b, want %0b", o_last, e.last));
            end
        end
    end

    // A small graph with a chain, extreme costs, a repeated edge, a dropped
    // edge, a self-loop, unreachable and outside queries, the unused command
    // and finally a negative cycle.
    task automatic test_directed();
        write_count(5'd4);
        send_request(mpsw_pkg::CMD_CLEAR, 0, 0, 0);
        send_request(mpsw_pkg::CMD_ADD, 0, 1, 16'sd32767);
        send_request(mpsw_pkg::CMD_ADD, 1, 2, -16'sd32768);
        send_request(mpsw_pkg::CMD_ADD, 2, 3, 16'sd7);
        send_request(mpsw_pkg::CMD_ADD, 0, 1, 16'sd3);
        send_request(mpsw_pkg::CMD_ADD, 5, 1, 16'sd1);
        send_request(mpsw_pkg::CMD_ADD, 15, 15, -16'sd1);
        send_request(mpsw_pkg::CMD_ADD, 3, 3, 16'sd0);
        send_request(mpsw_pkg::CMD_QUERY, 0, 3, 0);
        send_request(mpsw_pkg::CMD_QUERY, 3, 3, 0);
        send_request(mpsw_pkg::CMD_QUERY, 1, 1, 0);
        send_request(mpsw_pkg::CMD_QUERY, 3, 0, 0);
        send_request(mpsw_pkg::CMD_QUERY, 0, 9, 0);
        send_request(mpsw_pkg::CMD_QUERY, 15, 2, 0);
        send_request(CMD_UNUSED, 4'hf, 4'hf, 16'hffff);
        send_request(mpsw_pkg::CMD_ADD, 3, 0, -16'sd100);
        send_request(mpsw_pkg::CMD_QUERY, 0, 2, 0);
    endtask

    // The register at and beyond both ends of its range. The full-size graph
    // is slow, so it sees only two queries.
    task automatic test_count_extremes();
        write_count(5'd0);
        send_request(mpsw_pkg::CMD_CLEAR, 0, 0, 0);
        send_request(mpsw_pkg::CMD_ADD, 0, 0, 16'sd9);
        send_request(mpsw_pkg::CMD_QUERY, 0, 0, 0);
        send_request(mpsw_pkg::CMD_QUERY, 0, 1, 0);
        write_count(5'd1);
        send_request(mpsw_pkg::CMD_CLEAR, 0, 0, 0);
        send_request(mpsw_pkg::CMD_QUERY, 0, 0, 0);
        write_count(5'd31);
        send_request(mpsw_pkg::CMD_CLEAR, 0, 0, 0);
        for (int v = 0; v < NV - 1; v++) send_request(mpsw_pkg::CMD_ADD, v, v + 1, 16'sd1000);
        send_request(mpsw_pkg::CMD_QUERY, 0, 15, 0);
        write_count(5'd16);
        send_request(mpsw_pkg::CMD_CLEAR, 0, 0, 0);
        send_request(mpsw_pkg::CMD_ADD, 15, 0, -16'sd5);
        send_request(mpsw_pkg::CMD_ADD, 0, 15, 16'sd5);
        send_request(mpsw_pkg::CMD_QUERY, 0, 15, 0);
    endtask

    // The receiver holds off for a long stretch while queries keep coming,
    // so the output register fills and the input side stalls.
    task automatic test_backpressure();
        write_count(5'd3);
        send_request(mpsw_pkg::CMD_CLEAR, 0, 0, 0);
        send_request(mpsw_pkg::CMD_ADD, 0, 1, 16'sd4);
        send_request(mpsw_pkg::CMD_ADD, 1, 2, 16'sd6);
        hold_left = 3000;
        for (int q = 0; q < 6; q++) send_request(mpsw_pkg::CMD_QUERY, 0, q % 3, 0);
    endtask

    // Mostly well-formed sessions: set a size, clear, load edges, query.
    // A share of the items is noise: the unused command, edges outside the
    // graph and queries on any vertex.
    task automatic test_random(input int target);
        int sent, n, adds, qs, a, b;
        logic signed [15:0] c;
        sent = 0;
        while (sent < target) begin
            if ($urandom_range(9) == 0) n = $urandom_range(3);
            else n = $urandom_range(2, 6);
            write_count(n[4:0]);
            if (n < 1) n = 1;
            send_request(mpsw_pkg::CMD_CLEAR, 0, 0, 0);
            adds = $urandom_range(3, 10);
            for (int e = 0; e < adds; e++) begin
                if ($urandom_range(7) == 0) begin
                    send_request($urandom_range(1) ? CMD_UNUSED : mpsw_pkg::CMD_ADD,
                                 $urandom_range(15), $urandom_range(15), 16'($urandom));
                end else begin
                    a = $urandom_range(n - 1);
                    b = $urandom_range(n - 1);
                    case ($urandom_range(7))
                        0: c = 16'($urandom);
                        1: c = -$signed(16'($urandom_range(20)));
                        default: c = 16'($urandom_range(50));
                    endcase
                    send_request(mpsw_pkg::CMD_ADD, a, b, c);
                end
            end
            qs = $urandom_range(1, 3);
            for (int q = 0; q < qs; q++) begin
                if ($urandom_range(5) == 0) send_request(mpsw_pkg::CMD_QUERY,
                                                         $urandom_range(15),
                                                         $urandom_range(15), 16'($urandom));
                else send_request(mpsw_pkg::CMD_QUERY, $urandom_range(n - 1),
                                  $urandom_range(n - 1), 16'($urandom));
            end
            sent += 1 + adds + qs;
        end
    endtask

    initial begin
        error_count   = 0;
        hold_left     = 0;
        send_idle_pct = 17;
        recv_idle_pct = 53;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_cmd         = mpsw_pkg::CMD_CLEAR;
        i_from_vertex = '0;
        i_to_vertex   = '0;
        i_edge_cost   = '0;
        i_out_ready   = 1'b0;
        count_reg     = mpsw_pkg::VC_RESET;
        graph_clear();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_count_extremes();
        test_backpressure();
        test_random(15);
        send_idle_pct = 53;
        recv_idle_pct = 17;
        test_random(15);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(15);

        wait_quiet();
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Hard stop far beyond the slowest correct run.
    initial begin
        #40_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
